@@ rtl/assert_macros.svh @@
// assertion macros for the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define ASSERT_CK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the block clock aclk and reset aresetn
`define ASSERT_DEF(label, prop, msg) \
    `ASSERT_CK(label, aclk, aresetn, prop, msg)

`endif

@@ rtl/cfra_pkg.sv @@
// types and constants of the contiguous free-run allocator
// used by cfra_ctrl, cfra_dp, the top level and the checker; no dependencies
package cfra_pkg;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] row_index;
        logic [3:0] col_index;
        logic [1:0] new_state;
        logic [3:0] run_length;
    } in_item_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] slot_state;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_ALLOC = 2'd2
    } kind_t;

    localparam logic [1:0] SLOT_FREE     = 2'd0;
    localparam logic [1:0] SLOT_RESERVED = 2'd1;
    localparam logic [1:0] SLOT_TAKEN    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_MODIFY,
        S_SCAN,
        S_CHECK,
        S_DONE
    } fsm_state_t;

    typedef enum logic [1:0] {
        ADDR_REQ,
        ADDR_CNT,
        ADDR_CNT_DEC
    } addr_sel_t;

    typedef enum logic [1:0] {
        RES_FAIL,
        RES_OK,
        RES_READ
    } res_sel_t;

    typedef struct packed {
        logic      load_req;
        logic      rd_en;
        addr_sel_t addr_sel;
        logic      cnt_dec;
        logic      wr_slot;
        logic      wr_run;
        logic      pend_load;
        res_sel_t  pend_sel;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       coords_ok;
        logic       state_ok;
        logic       len_ok;
        logic       hit;
        logic       cnt_zero;
        logic       out_free;
    } dp_status_t;

endpackage

@@ rtl/contiguous_free_run_allocator.sv @@
// path: IDLE, DECODE, FETCH/MODIFY (write/read) or SCAN/CHECK of up to ROW_COUNT rows (allocate), DONE
// one transaction at a time; the next is taken the cycle after the output register is loaded;
// the allocate search fetches one row per cycle from the single-port row store
// reset: aresetn synchronous, active low; all slots read free afterwards through per-row valid bits
// top level; depends on cfra_pkg, cfra_ctrl and cfra_dp
module contiguous_free_run_allocator #(
    parameter int ROW_COUNT = 8,
    parameter int COL_COUNT = 10,
    parameter int MAX_RUN   = 9
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cfra_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cfra_pkg::out_item_t  m_item
);

    cfra_pkg::ctrl_cmd_t  cmd;
    cfra_pkg::dp_status_t status;

    cfra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cfra_dp #(
        .ROW_COUNT (ROW_COUNT),
        .COL_COUNT (COL_COUNT),
        .MAX_RUN   (MAX_RUN)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .status  (status),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_item  (m_item)
    );

endmodule

@@ rtl/cfra_ctrl.sv @@
// controller state machine of the allocator
// depends on cfra_pkg; drives the command struct into cfra_dp
module cfra_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cfra_pkg::dp_status_t  status,
    output cfra_pkg::ctrl_cmd_t   cmd
);

    cfra_pkg::fsm_state_t state_reg;
    cfra_pkg::fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cfra_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cfra_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = cfra_pkg::S_DECODE;
                end
            end
            cfra_pkg::S_DECODE: begin
                unique case (status.kind)
                    cfra_pkg::KIND_WRITE: begin
                        state_next = (status.coords_ok && status.state_ok) ?
                                     cfra_pkg::S_FETCH : cfra_pkg::S_DONE;
                    end
                    cfra_pkg::KIND_READ: begin
                        state_next = status.coords_ok ? cfra_pkg::S_FETCH : cfra_pkg::S_DONE;
                    end
                    cfra_pkg::KIND_ALLOC: begin
                        state_next = status.len_ok ? cfra_pkg::S_SCAN : cfra_pkg::S_DONE;
                    end
                    default: begin
                        state_next = cfra_pkg::S_DONE;
                    end
                endcase
            end
            cfra_pkg::S_FETCH:  state_next = cfra_pkg::S_MODIFY;
            cfra_pkg::S_MODIFY: state_next = cfra_pkg::S_DONE;
            cfra_pkg::S_SCAN:   state_next = cfra_pkg::S_CHECK;
            cfra_pkg::S_CHECK: begin
                if (status.hit || status.cnt_zero) begin
                    state_next = cfra_pkg::S_DONE;
                end
            end
            cfra_pkg::S_DONE: begin
                if (status.out_free) begin
                    state_next = cfra_pkg::S_IDLE;
                end
            end
            default: state_next = cfra_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.addr_sel = cfra_pkg::ADDR_REQ;
        cmd.pend_sel = cfra_pkg::RES_FAIL;
        s_ready      = 1'b0;
        unique case (state_reg)
            cfra_pkg::S_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            cfra_pkg::S_DECODE: begin
                // rejected requests go straight to the result
                cmd.pend_load = 1'b1;
                cmd.pend_sel  = cfra_pkg::RES_FAIL;
            end
            cfra_pkg::S_FETCH: begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = cfra_pkg::ADDR_REQ;
            end
            cfra_pkg::S_MODIFY: begin
                cmd.pend_load = 1'b1;
                if (status.kind == cfra_pkg::KIND_WRITE) begin
                    cmd.wr_slot  = 1'b1;
                    cmd.pend_sel = cfra_pkg::RES_OK;
                end else begin
                    cmd.pend_sel = cfra_pkg::RES_READ;
                end
            end
            cfra_pkg::S_SCAN: begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = cfra_pkg::ADDR_CNT;
            end
            cfra_pkg::S_CHECK: begin
                if (status.hit) begin
                    cmd.wr_run    = 1'b1;
                    cmd.pend_load = 1'b1;
                    cmd.pend_sel  = cfra_pkg::RES_OK;
                end else if (status.cnt_zero) begin
                    cmd.pend_load = 1'b1;
                    cmd.pend_sel  = cfra_pkg::RES_FAIL;
                end else begin
                    // fetch the next lower row while this one is checked
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = cfra_pkg::ADDR_CNT_DEC;
                    cmd.cnt_dec  = 1'b1;
                end
            end
            cfra_pkg::S_DONE: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                cmd.load_req = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/cfra_dp.sv @@
// datapath of the allocator: request register, row store, window search, result registers
// depends on cfra_pkg; commanded by cfra_ctrl
module cfra_dp #(
    parameter int ROW_COUNT = 8,
    parameter int COL_COUNT = 10,
    parameter int MAX_RUN   = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfra_pkg::in_item_t    s_item,
    input  cfra_pkg::ctrl_cmd_t   cmd,
    output cfra_pkg::dp_status_t  status,
    input  logic                  m_ready,
    output logic                  m_valid,
    output cfra_pkg::out_item_t   m_item
);

    localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int COL_W = (COL_COUNT > 1) ? $clog2(COL_COUNT) : 1;

    typedef logic [COL_COUNT-1:0][1:0] row_t;

    cfra_pkg::in_item_t  req_reg;
    logic [ROW_W-1:0]    cnt_reg;
    logic [ROW_W-1:0]    row_addr;
    logic [COL_W-1:0]    col_addr;
    logic [ROW_W-1:0]    rd_addr;
    logic [ROW_W-1:0]    wr_addr;
    logic                wr_en;
    row_t                wr_row;

    row_t                mem [ROW_COUNT];
    logic [ROW_COUNT-1:0] row_valid_reg;
    row_t                rd_raw_reg;
    logic                rd_valid_reg;
    row_t                rd_row;

    logic [COL_COUNT-1:0] free_vec;
    logic [COL_COUNT-1:0] win_ok;
    logic [COL_COUNT-1:0] run_mask;
    logic                 hit;

    cfra_pkg::out_item_t pend_reg;
    cfra_pkg::out_item_t pend_next;
    cfra_pkg::out_item_t out_item_reg;
    logic                out_valid_reg;

    // request and row counter
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_item;
            cnt_reg <= ROW_W'(ROW_COUNT - 1);
        end else if (cmd.cnt_dec) begin
            cnt_reg <= cnt_reg - ROW_W'(1);
        end
    end

    assign row_addr = ROW_W'(req_reg.row_index);
    assign col_addr = COL_W'(req_reg.col_index);

    always_comb begin
        unique case (cmd.addr_sel)
            cfra_pkg::ADDR_REQ:     rd_addr = row_addr;
            cfra_pkg::ADDR_CNT:     rd_addr = cnt_reg;
            cfra_pkg::ADDR_CNT_DEC: rd_addr = cnt_reg - ROW_W'(1);
            default:                rd_addr = cnt_reg;
        endcase
    end

    assign wr_en   = cmd.wr_slot || cmd.wr_run;
    assign wr_addr = cmd.wr_run ? cnt_reg : row_addr;

    // row store, one row per entry, registered read
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_raw_reg   <= mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
    end

    // a row never written since reset reads as all free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (wr_en) begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_row = rd_valid_reg ? rd_raw_reg : '0;

    // all window ends of the fetched row checked at once
    always_comb begin
        for (int c = 0; c < COL_COUNT; c++) begin
            free_vec[c] = (rd_row[c] == cfra_pkg::SLOT_FREE);
        end
        for (int e = 0; e < COL_COUNT; e++) begin
            win_ok[e] = 1'b1;
            for (int i = 0; i < MAX_RUN; i++) begin
                if (i < int'(req_reg.run_length)) begin
                    if (e - i < 0) begin
                        win_ok[e] = 1'b0;
                    end else if (!free_vec[e - i]) begin
                        win_ok[e] = 1'b0;
                    end
                end
            end
        end
        // rightmost fitting end wins
        hit      = 1'b0;
        run_mask = '0;
        for (int e = 0; e < COL_COUNT; e++) begin
            if (win_ok[e]) begin
                hit = 1'b1;
                for (int c = 0; c < COL_COUNT; c++) begin
                    run_mask[c] = (c <= e) && (c > e - int'(req_reg.run_length));
                end
            end
        end
    end

    always_comb begin
        wr_row = rd_row;
        if (cmd.wr_run) begin
            for (int c = 0; c < COL_COUNT; c++) begin
                if (run_mask[c]) begin
                    wr_row[c] = cfra_pkg::SLOT_TAKEN;
                end
            end
        end else begin
            wr_row[col_addr] = req_reg.new_state;
        end
    end

    // status toward the controller
    always_comb begin
        status.kind      = req_reg.kind;
        status.coords_ok = (32'(req_reg.row_index) < ROW_COUNT) &&
                           (32'(req_reg.col_index) < COL_COUNT);
        status.state_ok  = (req_reg.new_state <= cfra_pkg::SLOT_TAKEN);
        status.len_ok    = (req_reg.run_length != 4'd0) &&
                           (32'(req_reg.run_length) <= MAX_RUN) &&
                           (32'(req_reg.run_length) <= COL_COUNT);
        status.hit       = hit;
        status.cnt_zero  = (cnt_reg == '0);
        status.out_free  = !out_valid_reg || m_ready;
    end

    // result waiting for the output register
    always_comb begin
        unique case (cmd.pend_sel)
            cfra_pkg::RES_OK: begin
                pend_next.ok         = 1'b1;
                pend_next.slot_state = cfra_pkg::SLOT_FREE;
            end
            cfra_pkg::RES_READ: begin
                pend_next.ok         = 1'b1;
                pend_next.slot_state = rd_row[col_addr];
            end
            default: begin
                pend_next.ok         = 1'b0;
                pend_next.slot_state = cfra_pkg::SLOT_FREE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.pend_load) begin
            pend_reg <= pend_next;
        end
        if (cmd.out_load) begin
            out_item_reg <= pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

@@ rtl/cfra_checker.sv @@
// port-level checker of the allocator and its bind to the top level
// depends on cfra_pkg and assert_macros.svh
`include "assert_macros.svh"

module cfra_port_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input cfra_pkg::out_item_t m_item
);

    logic [1:0] open_reg;
    logic [1:0] open_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // transactions taken in but not yet delivered
    always_comb begin
        open_next = open_reg;
        if (in_acc && !out_acc) begin
            open_next = open_reg + 2'd1;
        end else if (out_acc && !in_acc) begin
            open_next = open_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 2'd0;
        end else begin
            open_reg <= open_next;
        end
    end

    `ASSERT_DEF(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_item), "result not held")
    `ASSERT_DEF(a_one_at_a_time, in_acc |=> !s_ready, "ready right after an accepted transaction")
    `ASSERT_DEF(a_open_bound, open_reg != 2'd3, "more than two transactions in flight")
    `ASSERT_DEF(a_no_spurious, m_valid |-> open_reg != 2'd0, "result without a pending transaction")

endmodule

bind contiguous_free_run_allocator cfra_port_checker u_cfra_port_checker (.*);
